[rtl/bfi_pkg.sv]
// Shared constants for the Brainfuck interpreter core: sizes, modes, result kinds, opcodes.
`timescale 1ns / 1ps
package bfi_pkg;

    localparam int PROG_DEPTH_DEF = 4096;
    localparam int MEM_DEPTH_DEF  = 32768;
    localparam int CELL_BITS_DEF  = 64;
    localparam int MEM_LIMIT_RST  = 30000;

    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_STEP    = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    localparam logic [2:0] KIND_OUTPUT    = 3'd0;
    localparam logic [2:0] KIND_HALT      = 3'd1;
    localparam logic [2:0] KIND_LEFT      = 3'd2;
    localparam logic [2:0] KIND_RIGHT     = 3'd3;
    localparam logic [2:0] KIND_INPUT     = 3'd4;
    localparam logic [2:0] KIND_UNMATCHED = 3'd5;

    localparam logic [7:0] OP_INC    = 8'h2B;  // '+'
    localparam logic [7:0] OP_DEC    = 8'h2D;  // '-'
    localparam logic [7:0] OP_LEFT   = 8'h3C;  // '<'
    localparam logic [7:0] OP_MOVE_R = 8'h3E;  // '>'
    localparam logic [7:0] OP_OUT    = 8'h2E;  // '.'
    localparam logic [7:0] OP_IN     = 8'h2C;  // ','
    localparam logic [7:0] OP_OPEN   = 8'h5B;  // '['
    localparam logic [7:0] OP_CLOSE  = 8'h5D;  // ']'

endpackage

[rtl/bfi_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module bfi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/bf_interpreter_core.sv]
// Top level of the stepwise Brainfuck interpreter core.
// A load or restart item, a step while halted and an unknown mode are handled in the idle
// state. A step reads program and cell memory, then decodes and writes the cell, and passes
// through the emit state when it returns a result; a step past the program end goes straight
// to the emit state. A bracket scan reads one program position after another through the
// registered read port of the program memory (a forward scan that runs off the program also
// visits the end position). A step that returns a result holds in the emit state while the
// output register still has an unaccepted item. The cell memory needs no clearing pass: a
// fill count marks the cells written since reset or restart, all others read zero.
// The input is not ready while an item is in progress; a finished result waits in the
// output register while the next item is taken.
`timescale 1ns / 1ps
module bf_interpreter_core #(
    parameter int PROG_DEPTH = bfi_pkg::PROG_DEPTH_DEF,
    parameter int MEM_DEPTH  = bfi_pkg::MEM_DEPTH_DEF,
    parameter int CELL_BITS  = bfi_pkg::CELL_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] prog_byte
    input  logic [1:0]  i_s_tuser,   // [1:0] mode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] out_byte
    output logic [2:0]  o_m_tuser,   // [2:0] out_kind
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    localparam int PA_W  = $clog2(PROG_DEPTH);
    localparam int LEN_W = $clog2(PROG_DEPTH + 1);
    localparam int CP_W  = $clog2(MEM_DEPTH);
    localparam int LIM_W = $clog2(MEM_DEPTH + 1);
    localparam int LIM_RST = (bfi_pkg::MEM_LIMIT_RST > MEM_DEPTH) ?
                             MEM_DEPTH : bfi_pkg::MEM_LIMIT_RST;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_F,
        S_SCAN_B,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_ip, n_ip;
    logic [LEN_W-1:0] r_p, n_p;
    logic [LEN_W-1:0] r_depth, n_depth;
    logic [CP_W-1:0]  r_cp, n_cp;
    logic [LIM_W-1:0] r_fill, n_fill;
    logic [LIM_W-1:0] r_limit;
    logic             r_halted, n_halted;
    logic [7:0]       r_res_byte, n_res_byte;
    logic [2:0]       r_res_kind, n_res_kind;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_byte, n_out_byte;
    logic [2:0]       r_out_kind, n_out_kind;

    logic                 s_fire;
    logic                 prog_we;
    logic [PA_W-1:0]      prog_raddr;
    logic [7:0]           op;
    logic                 cell_we;
    logic [CELL_BITS-1:0] cell_wdata;
    logic [CELL_BITS-1:0] cell_rdata;
    logic [CELL_BITS-1:0] cell_val;
    logic                 cp_at_fill;
    logic [LIM_W-1:0]     cfg_limit;
    logic [16:0]          cfg_ext;

    bfi_ram #(.WIDTH(8), .DEPTH(PROG_DEPTH)) u_prog (
        .i_clk   (i_clk),
        .i_we    (prog_we),
        .i_waddr (r_len[PA_W-1:0]),
        .i_wdata (i_s_tdata),
        .i_raddr (prog_raddr),
        .o_rdata (op)
    );

    bfi_ram #(.WIDTH(CELL_BITS), .DEPTH(MEM_DEPTH)) u_cells (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_waddr (r_cp),
        .i_wdata (cell_wdata),
        .i_raddr (r_cp),
        .o_rdata (cell_rdata)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tuser  = r_out_kind;

    assign cp_at_fill = (LIM_W'(r_cp) == r_fill);
    assign cell_val   = (LIM_W'(r_cp) < r_fill) ? cell_rdata : '0;

    // mem_limit is clamped to 1 .. MEM_DEPTH on write
    assign cfg_ext = {1'b0, i_cfg_wdata};
    always_comb begin
        if (i_cfg_wdata == 16'd0) begin
            cfg_limit = LIM_W'(1);
        end else if (cfg_ext > 17'(MEM_DEPTH)) begin
            cfg_limit = LIM_W'(MEM_DEPTH);
        end else begin
            cfg_limit = LIM_W'(cfg_ext);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_ip        = r_ip;
        n_p         = r_p;
        n_depth     = r_depth;
        n_cp        = r_cp;
        n_fill      = r_fill;
        n_halted    = r_halted;
        n_res_byte  = r_res_byte;
        n_res_kind  = r_res_kind;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_byte  = r_out_byte;
        n_out_kind  = r_out_kind;
        prog_we     = 1'b0;
        prog_raddr  = r_ip[PA_W-1:0];
        cell_we     = 1'b0;
        cell_wdata  = '0;

        case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    case (i_s_tuser)
                        bfi_pkg::MODE_LOAD: begin
                            if (r_len < LEN_W'(PROG_DEPTH)) begin
                                prog_we = 1'b1;
                                n_len   = r_len + 1'b1;
                            end
                        end
                        bfi_pkg::MODE_STEP: begin
                            if (!r_halted) begin
                                if (r_ip >= r_len) begin
                                    n_halted   = 1'b1;
                                    n_res_byte = 8'd0;
                                    n_res_kind = bfi_pkg::KIND_HALT;
                                    n_state    = S_EMIT;
                                end else begin
                                    n_state = S_DECODE;
                                end
                            end
                        end
                        bfi_pkg::MODE_RESTART: begin
                            n_len    = '0;
                            n_ip     = '0;
                            n_cp     = '0;
                            n_fill   = '0;
                            n_depth  = '0;
                            n_halted = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_DECODE: begin
                n_state = S_IDLE;
                n_ip    = r_ip + 1'b1;
                case (op)
                    bfi_pkg::OP_INC, bfi_pkg::OP_DEC: begin
                        cell_we    = 1'b1;
                        cell_wdata = (op == bfi_pkg::OP_INC) ? cell_val + 1'b1
                                                             : cell_val - 1'b1;
                        if (cp_at_fill) begin
                            n_fill = r_fill + 1'b1;
                        end
                    end
                    bfi_pkg::OP_LEFT: begin
                        if (r_cp == '0) begin
                            n_ip       = r_ip;
                            n_halted   = 1'b1;
                            n_res_byte = 8'd0;
                            n_res_kind = bfi_pkg::KIND_LEFT;
                            n_state    = S_EMIT;
                        end else begin
                            n_cp = r_cp - 1'b1;
                        end
                    end
                    bfi_pkg::OP_MOVE_R: begin
                        if (LIM_W'(r_cp) + 1'b1 >= r_limit) begin
                            n_ip       = r_ip;
                            n_halted   = 1'b1;
                            n_res_byte = 8'd0;
                            n_res_kind = bfi_pkg::KIND_RIGHT;
                            n_state    = S_EMIT;
                        end else begin
                            // initialize the current cell before leaving it unwritten
                            if (cp_at_fill) begin
                                cell_we = 1'b1;
                                n_fill  = r_fill + 1'b1;
                            end
                            n_cp = r_cp + 1'b1;
                        end
                    end
                    bfi_pkg::OP_OUT: begin
                        n_res_byte = cell_val[7:0];
                        n_res_kind = bfi_pkg::KIND_OUTPUT;
                        n_state    = S_EMIT;
                    end
                    bfi_pkg::OP_IN: begin
                        n_ip       = r_ip;
                        n_halted   = 1'b1;
                        n_res_byte = 8'd0;
                        n_res_kind = bfi_pkg::KIND_INPUT;
                        n_state    = S_EMIT;
                    end
                    bfi_pkg::OP_OPEN: begin
                        if (cell_val == '0) begin
                            n_ip       = r_ip;
                            n_p        = r_ip + 1'b1;
                            n_depth    = '0;
                            prog_raddr = n_p[PA_W-1:0];
                            n_state    = S_SCAN_F;
                        end
                    end
                    bfi_pkg::OP_CLOSE: begin
                        if (cell_val != '0) begin
                            n_ip = r_ip;
                            if (r_ip == '0) begin
                                n_halted   = 1'b1;
                                n_res_byte = 8'd0;
                                n_res_kind = bfi_pkg::KIND_UNMATCHED;
                                n_state    = S_EMIT;
                            end else begin
                                n_p        = r_ip - 1'b1;
                                n_depth    = '0;
                                prog_raddr = n_p[PA_W-1:0];
                                n_state    = S_SCAN_B;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // op holds the program byte at r_p
            S_SCAN_F: begin
                n_p        = r_p + 1'b1;
                prog_raddr = n_p[PA_W-1:0];
                if (r_p >= r_len) begin
                    n_depth    = '0;
                    n_halted   = 1'b1;
                    n_res_byte = 8'd0;
                    n_res_kind = bfi_pkg::KIND_UNMATCHED;
                    n_state    = S_EMIT;
                end else if (op == bfi_pkg::OP_CLOSE) begin
                    if (r_depth == '0) begin
                        n_ip    = r_p + 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_depth = r_depth - 1'b1;
                    end
                end else if (op == bfi_pkg::OP_OPEN) begin
                    n_depth = r_depth + 1'b1;
                end
            end

            S_SCAN_B: begin
                n_p        = r_p - 1'b1;
                prog_raddr = n_p[PA_W-1:0];
                if (op == bfi_pkg::OP_OPEN && r_depth == '0) begin
                    n_ip    = r_p + 1'b1;
                    n_state = S_IDLE;
                end else begin
                    if (op == bfi_pkg::OP_OPEN) begin
                        n_depth = r_depth - 1'b1;
                    end else if (op == bfi_pkg::OP_CLOSE) begin
                        n_depth = r_depth + 1'b1;
                    end
                    if (r_p == '0) begin
                        n_depth    = '0;
                        n_halted   = 1'b1;
                        n_res_byte = 8'd0;
                        n_res_kind = bfi_pkg::KIND_UNMATCHED;
                        n_state    = S_EMIT;
                    end
                end
            end

            S_EMIT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_res_byte;
                    n_out_kind  = r_res_kind;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_ip        <= '0;
            r_p         <= '0;
            r_depth     <= '0;
            r_cp        <= '0;
            r_fill      <= '0;
            r_limit     <= LIM_W'(LIM_RST);
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_ip        <= n_ip;
            r_p         <= n_p;
            r_depth     <= n_depth;
            r_cp        <= n_cp;
            r_fill      <= n_fill;
            r_halted    <= n_halted;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_limit <= cfg_limit;
            end
        end
        r_res_byte <= n_res_byte;
        r_res_kind <= n_res_kind;
        r_out_byte <= n_out_byte;
        r_out_kind <= n_out_kind;
    end

    a_cp_within_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LIM_W'(r_cp) <= r_fill)
        else $error("cell pointer beyond initialized cells");

    a_ip_within_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ip <= r_len)
        else $error("instruction pointer beyond program length");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_F) |-> (r_p <= r_len))
        else $error("forward scan beyond program length");

    a_emit_after_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> ($past(r_state) != S_EMIT ? n_halted ||
            r_res_kind == bfi_pkg::KIND_OUTPUT : 1'b1))
        else $error("error result without halt");

endmodule

[bench/bf_interp_checker.sv]
// Checker for the interpreter core: predicts result items from the input and config traffic.
`timescale 1ns / 1ps
module bf_interp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] prog_byte
    input  logic [1:0]  i_s_tuser,   // [1:0] mode
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,   // [7:0] out_byte
    input  logic [2:0]  i_m_tuser,   // [2:0] out_kind
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output int          o_results_pending,
    output int          o_mismatch_count
);
    import bfi_pkg::*;

    typedef struct {
        logic [7:0] out_byte;
        logic [2:0] out_kind;
    } bf_result_t;

    bf_result_t                  expected_results [$];
    logic [7:0]                  prog_mem [PROG_DEPTH_DEF];
    logic [CELL_BITS_DEF-1:0]    cell_mem [int unsigned];
    int unsigned                 prog_len = 0;
    int unsigned                 ip = 0;
    int unsigned                 cp = 0;
    bit                          halted = 1'b0;
    logic [15:0]                 mem_limit = 16'(MEM_LIMIT_RST);
    int                          n_bad = 0;

    assign o_mismatch_count = n_bad;

    function automatic int unsigned cell_limit();
        if (mem_limit == 16'd0) return 1;
        if (int'(mem_limit) > MEM_DEPTH_DEF) return MEM_DEPTH_DEF;
        return int'(mem_limit);
    endfunction

    task automatic expect_result(input logic [7:0] b, input logic [2:0] k);
        bf_result_t r;
        r.out_byte = b;
        r.out_kind = k;
        expected_results.push_back(r);
    endtask

    task automatic clear_machine();
        cell_mem.delete();
        prog_len = 0;
        ip = 0;
        cp = 0;
        halted = 1'b0;
    endtask

    // one instruction; brackets jump to just past their partner
    task automatic exec_step();
        logic [CELL_BITS_DEF-1:0] cv;
        int unsigned nxt;
        int unsigned p;
        int unsigned nest;
        bit found;
        bit faulted;
        logic [2:0] fault;
        if (ip >= prog_len) begin
            halted = 1'b1;
            expect_result(8'h00, KIND_HALT);
            return;
        end
        cv = cell_mem.exists(cp) ? cell_mem[cp] : '0;
        nxt = ip + 1;
        faulted = 1'b0;
        fault = KIND_HALT;
        case (prog_mem[ip])
            OP_INC: cell_mem[cp] = cv + 1'b1;
            OP_DEC: cell_mem[cp] = cv - 1'b1;
            OP_LEFT: begin
                if (cp == 0) begin
                    faulted = 1'b1;
                    fault = KIND_LEFT;
                end else begin
                    cp--;
                end
            end
            OP_MOVE_R: begin
                if (cp + 1 >= cell_limit()) begin
                    faulted = 1'b1;
                    fault = KIND_RIGHT;
                end else begin
                    cp++;
                end
            end
            OP_OUT: expect_result(cv[7:0], KIND_OUTPUT);
            OP_IN: begin
                faulted = 1'b1;
                fault = KIND_INPUT;
            end
            OP_OPEN: begin
                if (cv == '0) begin
                    p = ip + 1;
                    nest = 0;
                    found = 1'b0;
                    while (!found && p < prog_len) begin
                        if (prog_mem[p] == OP_CLOSE && nest == 0) begin
                            found = 1'b1;
                        end else begin
                            if (prog_mem[p] == OP_CLOSE) nest--;
                            else if (prog_mem[p] == OP_OPEN) nest++;
                            p++;
                        end
                    end
                    if (found) begin
                        nxt = p + 1;
                    end else begin
                        faulted = 1'b1;
                        fault = KIND_UNMATCHED;
                    end
                end
            end
            OP_CLOSE: begin
                if (cv != '0) begin
                    p = ip;
                    nest = 0;
                    found = 1'b0;
                    while (!found && p > 0) begin
                        p--;
                        if (prog_mem[p] == OP_OPEN) begin
                            if (nest == 0) found = 1'b1;
                            else nest--;
                        end else if (prog_mem[p] == OP_CLOSE) begin
                            nest++;
                        end
                    end
                    if (found) begin
                        nxt = p + 1;
                    end else begin
                        faulted = 1'b1;
                        fault = KIND_UNMATCHED;
                    end
                end
            end
            default: ;
        endcase
        if (faulted) begin
            halted = 1'b1;
            expect_result(8'h00, fault);
        end else begin
            ip = nxt;
        end
    endtask

    task automatic apply_item(input logic [1:0] mode, input logic [7:0] data);
        case (mode)
            MODE_LOAD: begin
                if (prog_len < PROG_DEPTH_DEF) begin
                    prog_mem[prog_len] = data;
                    prog_len++;
                end
            end
            MODE_RESTART: clear_machine();
            MODE_STEP: if (!halted) exec_step();
            default: ;
        endcase
    endtask

    task automatic check_result(input logic [7:0] b, input logic [2:0] k);
        bf_result_t e;
        if (expected_results.size() == 0) begin
            n_bad++;
            if (n_bad <= 10)
                $display("%0t: unexpected item out_byte %02h out_kind %0d", $time, b, k);
            return;
        end
        e = expected_results.pop_front();
        if (e.out_byte !== b || e.out_kind !== k) begin
            n_bad++;
            if (n_bad <= 10)
                $display("%0t: mismatch out_byte exp %02h got %02h, out_kind exp %0d got %0d",
                         $time, e.out_byte, b, e.out_kind, k);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_machine();
            mem_limit = 16'(MEM_LIMIT_RST);
            expected_results.delete();
        end else begin
            if (i_cfg_we) mem_limit = i_cfg_wdata;
            if (i_s_tvalid && i_s_tready) apply_item(i_s_tuser, i_s_tdata);
            if (i_m_tvalid && i_m_tready) check_result(i_m_tdata, i_m_tuser);
        end
        o_results_pending <= expected_results.size();
    end

endmodule

[bench/tb_bf_interpreter_core.sv]
// Testbench top for the interpreter core: clock, reset, program stimulus and final verdict.
`timescale 1ns / 1ps
module tb_bf_interpreter_core;
    import bfi_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_NL       = 8'h0A;
    localparam int         SETTLE      = 4200;   // longest bracket scan plus margin
    localparam int         PHASE_ITEMS = 45;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic [1:0]  s_tuser = MODE_LOAD;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'h0000;

    int          results_pending;
    int          mismatch_count;
    int          items_sent = 0;
    int          burst_left = 0;
    int          halts_seen = 0;
    int          stall_style = 0;
    int          style_left = 0;
    logic [7:0]  prog_buf [$];

    always #5 i_clk = ~i_clk;

    bf_interpreter_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    bf_interp_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_s_tvalid        (s_tvalid),
        .i_s_tready        (s_tready),
        .i_s_tdata         (s_tdata),
        .i_s_tuser         (s_tuser),
        .i_m_tvalid        (m_tvalid),
        .i_m_tready        (m_tready),
        .i_m_tdata         (m_tdata),
        .i_m_tuser         (m_tuser),
        .i_cfg_we          (cfg_we),
        .i_cfg_wdata       (cfg_wdata),
        .o_results_pending (results_pending),
        .o_mismatch_count  (mismatch_count)
    );

    // receiver: switches between always ready, random, sparse and periodic stalls
    always @(posedge i_clk) begin
        if (style_left == 0) begin
            stall_style <= $urandom_range(0, 3);
            style_left <= $urandom_range(20, 300);
        end else begin
            style_left <= style_left - 1;
        end
        case (stall_style)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (style_left % 5) != 0;
        endcase
    end

    always @(posedge i_clk) begin
        if (m_tvalid && m_tready && m_tuser != KIND_OUTPUT) halts_seen <= halts_seen + 1;
    end

    task automatic send_item(input logic [1:0] mode, input logic [7:0] data);
        int gap;
        s_tuser <= mode;
        s_tdata <= data;
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        if (mode != MODE_UNUSED) items_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 20);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic load_prog();
        foreach (prog_buf[i]) send_item(MODE_LOAD, prog_buf[i]);
        prog_buf.delete();
    endtask

    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_op(inout int depth);
        int r;
        r = $urandom_range(0, 99);
        if (r < 24) return OP_INC;
        if (r < 34) return OP_DEC;
        if (r < 48) return OP_MOVE_R;
        if (r < 55) return OP_LEFT;
        if (r < 70) return OP_OUT;
        if (r < 80) begin
            depth++;
            return OP_OPEN;
        end
        if (r < 90) begin
            if (depth > 0) begin
                depth--;
                return OP_CLOSE;
            end
            return OP_INC;
        end
        if (r < 92) return OP_IN;
        if (r < 95) return CH_SPACE;
        if (r < 97) return CH_NL;
        return 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    // mostly balanced programs with random content; some raw byte noise
    task automatic run_random_program();
        int len;
        int depth;
        bit noisy;
        if ($urandom_range(0, 9) != 0) send_item(MODE_RESTART, 8'($urandom));
        noisy = ($urandom_range(0, 7) == 0);
        len = $urandom_range(1, 16);
        depth = 0;
        for (int i = 0; i < len; i++) begin
            send_item(MODE_LOAD, noisy ? 8'($urandom_range(0, 255)) : pick_op(depth));
            if ($urandom_range(0, 39) == 0) send_item(MODE_UNUSED, 8'($urandom));
        end
        if ($urandom_range(0, 5) != 0) repeat (depth) send_item(MODE_LOAD, OP_CLOSE);
        repeat ($urandom_range(2, 2 * len + 6)) send_item(MODE_STEP, 8'($urandom));
    endtask

    initial begin
        #(30_000_000);
        $display("FAIL");
        $finish;
    end

    initial begin
        logic [15:0] limit_plan [$];
        int          target;
        int          halts_before;
        limit_plan = {16'd0, 16'd1, 16'd2, 16'd5, 16'd32768, 16'($urandom), 16'd3};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty program, halted steps, wrap, skips, nested forward scan,
        // unmatched close with zero cell, unsupported input, load while halted
        send_item(MODE_UNUSED, 8'hA5);
        send_item(MODE_STEP, 8'h00);
        send_item(MODE_STEP, 8'hFF);
        send_item(MODE_RESTART, 8'h00);
        prog_buf = {OP_DEC, OP_OUT, OP_INC, OP_OUT, CH_SPACE, CH_NL, OP_OPEN, OP_OPEN,
                    OP_CLOSE, OP_CLOSE, OP_CLOSE, OP_MOVE_R, OP_IN};
        load_prog();
        repeat (10) send_item(MODE_STEP, 8'h00);
        send_item(MODE_LOAD, OP_OUT);
        send_item(MODE_STEP, 8'h00);
        send_item(MODE_RESTART, 8'hFF);

        target = items_sent + PHASE_ITEMS;
        while (items_sent < target) run_random_program();
        foreach (limit_plan[i]) begin
            drain_and_settle();
            write_limit(limit_plan[i]);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) run_random_program();
        end

        // small limit: the loop walks right until the bound
        drain_and_settle();
        write_limit(16'd40);
        send_item(MODE_RESTART, 8'h00);
        prog_buf = {OP_INC, OP_OPEN};
        repeat (16) prog_buf.push_back(OP_MOVE_R);
        prog_buf.push_back(OP_INC);
        prog_buf.push_back(OP_CLOSE);
        load_prog();
        halts_before = halts_seen;
        while (halts_seen == halts_before) send_item(MODE_STEP, 8'($urandom));

        drain_and_settle();
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
